/* design/fbls_pkg.sv */
// Package: types, constants and codes for the fiber bundle load sharing core.
package fbls_pkg;

  localparam int NUM_FIBERS = 1024;
  localparam int IDX_W      = $clog2(NUM_FIBERS);
  localparam int CNT_W      = $clog2(NUM_FIBERS + 1);
  localparam int THR_W      = 32;
  localparam int LOAD_W     = 48;
  localparam int STEP_W     = 32;
  localparam int PROD_W     = LOAD_W + CNT_W;

  localparam logic [LOAD_W-1:0] LOAD_MAX    = {LOAD_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_MAX    = {STEP_W{1'b1}};
  localparam logic [31:0]       LOAD_DEFAULT = 32'd42949673;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_START = 2'd1,
    MODE_PASS  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_INITIAL_LOAD = 1'b0,
    CFG_LOAD_STEP    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [9:0]       fiber_index;
    logic [THR_W-1:0] threshold;
  } in_req_t;

  typedef struct packed {
    logic [31:0]       total_steps;
    logic [31:0]       avalanche_step;
    logic [10:0]       broken_now;
    logic [10:0]       surviving;
    logic [31:0]       event_number;
    logic [LOAD_W-1:0] current_load;
    logic              collapsed;
  } out_req_t;

endpackage

/* design/fbls_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fbls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/fbls_div.sv */
// Restoring divider: quotient of a product by a fiber count, one bit per cycle.
module fbls_div
  import fbls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam int BIT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [BIT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[CNT_W-1:0], quo_r[PROD_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = BIT_W'(PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == BIT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = busy_r && (cnt_r == BIT_W'(1));
  assign quotient = quo_nxt;

endmodule

/* design/fiber_bundle_load_sharing_step_core.sv */
// Top level: equal-load-sharing fiber bundle, one redistribution pass per pass request.
//
// Thresholds live in a 1024-entry RAM written by mode 0 requests. A pass request,
// unless the bundle has collapsed, sweeps the RAM once, reading each fiber and
// writing back a zero for each fiber that breaks, then runs a bit-serial division
// for the redistributed load when some fibers broke and some survive. The result
// sits in an output register; input stalls while a pass runs and while a result
// waits on a stalled receiver. Entries never written read as undefined, so every
// fiber must be written before the first pass.
module fiber_bundle_load_sharing_step_core
  import fbls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [31:0]       init_load_r, step_r;
  logic [LOAD_W-1:0] load_r, load_nxt;
  logic [31:0]       pass_r, pass_nxt, pie_r, pie_nxt, evt_r, evt_nxt;
  logic [CNT_W-1:0]  btot_r, btot_nxt, brk_r, brk_nxt, intact_r, intact_nxt;
  logic              coll_r, coll_nxt;
  logic [IDX_W:0]    ridx_r, ridx_nxt;
  logic [IDX_W-1:0]  cidx_r, cidx_nxt;
  logic              cval_r, cval_nxt;
  logic              ov_r, ov_nxt;
  out_req_t          od_r, od_nxt;

  logic              accept;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [THR_W-1:0]  ram_wdata, ram_rdata;
  logic              div_start, div_done;
  logic [PROD_W-1:0] div_quo, prod;
  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] add_val;
  logic [CNT_W:0]    btot_sum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE) || (ov_r && out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  fbls_ram #(.WIDTH(THR_W), .DEPTH(NUM_FIBERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (intact_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign ram_raddr = ridx_r[IDX_W-1:0];
  assign prod      = PROD_W'(load_r) * PROD_W'(brk_r);
  assign div_start = (state_r == ST_DRAIN) && !cval_r && (intact_r != '0) && (brk_r != '0);
  assign btot_sum  = {1'b0, btot_r} + {1'b0, brk_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && mode_t'(in_data.mode) == MODE_PASS) begin
          state_nxt = coll_r ? ST_OUT : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (ridx_r == (IDX_W+1)'(NUM_FIBERS)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!cval_r) begin
          state_nxt = div_start ? ST_DIV : ST_UPDATE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    load_nxt   = load_r;
    pass_nxt   = pass_r;
    pie_nxt    = pie_r;
    evt_nxt    = evt_r;
    btot_nxt   = btot_r;
    brk_nxt    = brk_r;
    intact_nxt = intact_r;
    coll_nxt   = coll_r;
    ridx_nxt   = ridx_r;
    cidx_nxt   = cidx_r;
    cval_nxt   = 1'b0;
    ov_nxt     = ov_r && out_stall;
    od_nxt     = od_r;
    ram_we     = 1'b0;
    ram_waddr  = cidx_r;
    ram_wdata  = '0;
    add_val    = '0;
    sum        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_data.mode))
            MODE_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = in_data.fiber_index[IDX_W-1:0];
              ram_wdata = in_data.threshold;
            end
            MODE_START: begin
              load_nxt = LOAD_W'(init_load_r);
              pass_nxt = '0;
              pie_nxt  = '0;
              evt_nxt  = 32'd1;
              btot_nxt = '0;
              coll_nxt = 1'b0;
            end
            MODE_PASS: begin
              brk_nxt  = '0;
              intact_nxt = '0;
              ridx_nxt = '0;
              if (!coll_r) begin
                pass_nxt = (pass_r == STEP_MAX) ? pass_r : pass_r + 1'b1;
                pie_nxt  = (pie_r == STEP_MAX) ? pie_r : pie_r + 1'b1;
              end
            end
            MODE_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP, ST_DRAIN: begin
        if (state_r == ST_SWEEP && ridx_r != (IDX_W+1)'(NUM_FIBERS)) begin
          ridx_nxt = ridx_r + 1'b1;
          cidx_nxt = ridx_r[IDX_W-1:0];
          cval_nxt = 1'b1;
        end
        if (cval_r && ram_rdata != '0) begin
          if (LOAD_W'(ram_rdata) <= load_r) begin
            ram_we  = 1'b1;
            brk_nxt = brk_r + 1'b1;
          end else begin
            intact_nxt = intact_r + 1'b1;
          end
        end
      end
      ST_DIV: begin
      end
      ST_UPDATE: begin
        btot_nxt = (btot_sum > (CNT_W+1)'(NUM_FIBERS)) ? CNT_W'(NUM_FIBERS)
                                                       : btot_sum[CNT_W-1:0];
        od_nxt.total_steps    = pass_r;
        od_nxt.avalanche_step = pie_r;
        od_nxt.broken_now     = 11'(brk_r);
        od_nxt.surviving      = 11'(CNT_W'(NUM_FIBERS) - btot_nxt);
        od_nxt.event_number   = evt_r;
        if (intact_r == '0) begin
          coll_nxt = 1'b1;
        end else if (brk_r == '0) begin
          add_val = LOAD_W'(step_r);
          evt_nxt = (evt_r == STEP_MAX) ? evt_r : evt_r + 1'b1;
          pie_nxt = '0;
        end else begin
          add_val = (div_quo > PROD_W'(LOAD_MAX)) ? LOAD_MAX : div_quo[LOAD_W-1:0];
        end
        sum      = {1'b0, load_r} + {1'b0, add_val};
        load_nxt = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
        od_nxt.current_load = load_nxt;
        od_nxt.collapsed    = coll_nxt;
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          if (coll_r) begin
            od_nxt.total_steps    = pass_r;
            od_nxt.avalanche_step = pie_r;
            od_nxt.surviving      = 11'(CNT_W'(NUM_FIBERS) - btot_r);
            od_nxt.event_number   = evt_r;
            od_nxt.current_load   = load_r;
            od_nxt.collapsed      = 1'b1;
            od_nxt.broken_now     = (brk_r != '0 && intact_r == '0) ? 11'(brk_r) : '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      init_load_r <= LOAD_DEFAULT;
      step_r      <= LOAD_DEFAULT;
      load_r      <= '0;
      pass_r      <= '0;
      pie_r       <= '0;
      evt_r       <= '0;
      btot_r      <= '0;
      coll_r      <= 1'b0;
      cval_r      <= 1'b0;
      ov_r        <= 1'b0;
      brk_r       <= '0;
      intact_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      load_r   <= load_nxt;
      pass_r   <= pass_nxt;
      pie_r    <= pie_nxt;
      evt_r    <= evt_nxt;
      btot_r   <= btot_nxt;
      coll_r   <= coll_nxt;
      cval_r   <= cval_nxt;
      ov_r     <= ov_nxt;
      brk_r    <= brk_nxt;
      intact_r <= intact_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_INITIAL_LOAD: init_load_r <= cfg_data;
          CFG_LOAD_STEP:    step_r      <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    ridx_r <= ridx_nxt;
    cidx_r <= cidx_nxt;
    od_r   <= od_nxt;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !accept) else $error("request accepted during pass");
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (ridx_r <= (IDX_W+1)'(NUM_FIBERS)))
    else $error("sweep index overrun");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, brk_r} + {1'b0, intact_r}) <= (CNT_W+1)'(NUM_FIBERS))
    else $error("fiber counts exceed bundle size");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (intact_r != '0)) else $error("division by zero fibers");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (state_r == ST_OUT)) else $error("update did not reach output");

endmodule

/* bench/tb_fiber_bundle_load_sharing_step_core.sv */
// Testbench: fiber bundle load sharing core, checked request by request against a predictor.
`timescale 1ns / 100ps

module tb_fiber_bundle_load_sharing_step_core
  import fbls_pkg::*;
;

  class bundle_scoreboard;
    logic [31:0]       thr_mem [NUM_FIBERS];
    logic [31:0]       init_load_reg;
    logic [31:0]       step_reg;
    logic [LOAD_W-1:0] load_q;
    logic [31:0]       pass_cnt;
    logic [31:0]       step_in_event;
    logic [31:0]       event_cnt;
    int                broken_sum;
    bit                collapsed_q;
    out_req_t          pending_q[$];
    int                mismatches;

    function new();
      foreach (thr_mem[i]) thr_mem[i] = '0;
      init_load_reg = LOAD_DEFAULT;
      step_reg = LOAD_DEFAULT;
      load_q = '0;
      pass_cnt = '0;
      step_in_event = '0;
      event_cnt = '0;
      broken_sum = 0;
      collapsed_q = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      if (idx == CFG_INITIAL_LOAD) init_load_reg = val;
      else step_reg = val;
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == STEP_MAX) ? v : v + 32'd1;
    endfunction

    function logic [LOAD_W-1:0] sat_add(logic [LOAD_W-1:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {17'd0, a} + {1'b0, b};
      return (s > {17'd0, LOAD_MAX}) ? LOAD_MAX : s[LOAD_W-1:0];
    endfunction

    function void note_request(in_req_t r);
      int broken;
      int intact;
      out_req_t res;
      logic [63:0] incr;
      broken = 0;
      intact = 0;
      case (mode_t'(r.mode))
        MODE_WRITE: thr_mem[r.fiber_index] = r.threshold;
        MODE_START: begin
          load_q = {16'd0, init_load_reg};
          pass_cnt = '0;
          step_in_event = '0;
          event_cnt = 32'd1;
          broken_sum = 0;
          collapsed_q = 1'b0;
        end
        MODE_PASS: begin
          if (!collapsed_q) begin
            pass_cnt = sat_inc(pass_cnt);
            step_in_event = sat_inc(step_in_event);
            for (int i = 0; i < NUM_FIBERS; i++) begin
              if (thr_mem[i] != 0) begin
                if ({16'd0, thr_mem[i]} <= load_q) begin
                  thr_mem[i] = '0;
                  broken++;
                end else begin
                  intact++;
                end
              end
            end
            broken_sum += broken;
            if (broken_sum > NUM_FIBERS) broken_sum = NUM_FIBERS;
          end
          res.total_steps = pass_cnt;
          res.avalanche_step = step_in_event;
          res.broken_now = broken[10:0];
          res.surviving = 11'(NUM_FIBERS - broken_sum);
          res.event_number = event_cnt;
          if (!collapsed_q) begin
            if (intact == 0) begin
              collapsed_q = 1'b1;
            end else if (broken == 0) begin
              load_q = sat_add(load_q, {32'd0, step_reg});
              event_cnt = sat_inc(event_cnt);
              step_in_event = '0;
            end else begin
              incr = ({16'd0, load_q} * 64'(broken)) / 64'(intact);
              load_q = sat_add(load_q, incr);
            end
          end
          res.current_load = load_q;
          res.collapsed = collapsed_q;
          pending_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_req_t got);
      out_req_t exp;
      bit bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp = pending_q.pop_front();
      bad = (exp.total_steps !== got.total_steps)
         || (exp.avalanche_step !== got.avalanche_step)
         || (exp.broken_now !== got.broken_now) || (exp.surviving !== got.surviving)
         || (exp.event_number !== got.event_number)
         || (exp.current_load !== got.current_load)
         || (exp.collapsed !== got.collapsed);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: expected %p got %p", exp, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_data;
  logic        out_valid;
  logic        out_stall;
  out_req_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  bundle_scoreboard sb;
  longint cycles;
  int     hold_off;

  localparam longint CYCLE_LIMIT = 64'd6000000;

  fiber_bundle_load_sharing_step_core dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int w;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off = hold_off - 1;
      end else if (out_valid && !out_stall) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        out_stall <= (w != 0);
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(in_req_t r);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic send_fields(mode_t m, int idx, logic [31:0] thr);
    in_req_t r;
    r.mode = m;
    r.fiber_index = idx[9:0];
    r.threshold = thr;
    send(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // write count fibers (all in order, or random picks); kind selects the threshold spread
  task automatic fill_fibers(int kind, int count);
    logic [31:0] t;
    int idx;
    for (int n = 0; n < count; n++) begin
      idx = (count >= NUM_FIBERS) ? n : $urandom_range(0, NUM_FIBERS - 1);
      case (kind)
        0: t = $urandom();
        1: t = (idx % 2) ? 32'hFFFF_FFFF : 32'd0;
        default: t = (n == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0100_0000);
      endcase
      send_fields(MODE_WRITE, idx, t);
    end
  endtask

  initial begin
    int pass_n;
    sb = new();
    cycles = 0;
    hold_off = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_INITIAL_LOAD;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: threshold extremes, ignored modes, collapse, saturation of load
    fill_fibers(1, NUM_FIBERS);
    send_fields(MODE_NONE, 1023, 32'hFFFF_FFFF);
    send_fields(MODE_PASS, 0, 0);
    send_fields(MODE_START, 0, 0);
    for (int k = 0; k < 4; k++) send_fields(MODE_PASS, k, 0);
    wait_idle();
    write_reg(CFG_INITIAL_LOAD, 32'hFFFF_FFFF);
    write_reg(CFG_LOAD_STEP, 32'hFFFF_FFFF);
    send_fields(MODE_START, 0, 0);
    for (int k = 0; k < 4; k++) send_fields(MODE_PASS, k, 0);
    wait_idle();
    write_reg(CFG_INITIAL_LOAD, 32'd0);
    write_reg(CFG_LOAD_STEP, 32'd0);
    fill_fibers(0, 32);
    send_fields(MODE_START, 0, 0);
    for (int k = 0; k < 3; k++) send_fields(MODE_PASS, k, 0);
    wait_idle();

    // random runs; long receiver hold-off in the first one
    for (int run = 0; run < 4; run++) begin
      write_reg(CFG_INITIAL_LOAD, (run == 0) ? LOAD_DEFAULT : $urandom_range(0, 32'h0200_0000));
      write_reg(CFG_LOAD_STEP, (run == 3) ? 32'h8000_0000 : $urandom_range(1, 32'h0100_0000));
      fill_fibers(run % 2 ? 2 : 0, 16);
      if (run == 0) hold_off = 3000;
      send_fields(MODE_START, 0, 0);
      pass_n = (run == 0) ? 20 : 12;
      for (int k = 0; k < pass_n; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_fields(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom());
        else
          send_fields(MODE_PASS, $urandom_range(0, 1023), $urandom());
      end
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* fiber_bundle_load_sharing_step_core.f */
design/fbls_pkg.sv
design/fbls_ram.sv
design/fbls_div.sv
design/fiber_bundle_load_sharing_step_core.sv
bench/tb_fiber_bundle_load_sharing_step_core.sv
